FILE: design/fdle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdle_pkg
// Shared types, constants and helpers for the fax DLE unstuffing unit.
// ----------------------------------------------------------------------------
package fdle_pkg;

  localparam int unsigned COUNT_BITS = 24;  // page byte counter width, 16..32
  localparam int unsigned REPORT_BITS = 24;
  localparam int unsigned TMO_BITS = 16;

  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [31:0] REPORT_MAX = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_START = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_IGNORE_CARRIER = 2'd0,
    CFG_IDLE_TMO       = 2'd1,
    CFG_ESC_TMO        = 2'd2,
    CFG_MIN_KEEP       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  ignore_carrier;
    logic [TMO_BITS-1:0]   idle_tmo;
    logic [TMO_BITS-1:0]   esc_tmo;
    logic [TMO_BITS-1:0]   min_keep;
  } cfg_t;

  typedef struct packed {
    logic                  page_done;
    logic                  esc_pending;
    logic [TMO_BITS-1:0]   idle_count;
    logic [TMO_BITS-1:0]   esc_count;
    logic [COUNT_BITS-1:0] byte_count;
  } st_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             out_byte;
    logic [REPORT_BITS-1:0] page_bytes;
    logic                   keep_page;
  } res_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: design/fdle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdle_core
// Per-word step logic: next page state and the optional result word.
// ----------------------------------------------------------------------------
module fdle_core (
  input  fdle_pkg::cfg_t  cfg_i,
  input  fdle_pkg::st_t   st_i,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            carrier_i,
  output fdle_pkg::st_t   st_o,
  output logic            res_valid_o,
  output fdle_pkg::res_t  res_o
);

  logic                            do_fin;
  logic                            do_emit;
  logic                            do_clr;
  fdle_pkg::kind_e                 fin_kind;
  logic [fdle_pkg::TMO_BITS:0]     esc_inc;
  logic [fdle_pkg::TMO_BITS:0]     idle_inc;
  logic [fdle_pkg::COUNT_BITS-1:0] cnt_next;
  logic [31:0]                     cnt_wide;

  assign esc_inc  = {1'b0, st_i.esc_count} + 1'b1;
  assign idle_inc = {1'b0, st_i.idle_count} + 1'b1;

  always_comb begin
    st_o     = st_i;
    do_fin   = 1'b0;
    do_emit  = 1'b0;
    do_clr   = 1'b0;
    fin_kind = fdle_pkg::KIND_GOOD;
    unique case (fdle_pkg::mode_e'(mode_i))
      fdle_pkg::MODE_START: begin
        st_o   = '0;
        do_clr = 1'b1;
      end
      fdle_pkg::MODE_BYTE: begin
        if (!st_i.page_done) begin
          st_o.idle_count = '0;
          if (st_i.esc_pending) begin
            st_o.esc_pending = 1'b0;
            st_o.esc_count   = '0;
            if (rx_byte_i == fdle_pkg::BYTE_ETX) begin
              do_fin = 1'b1;
            end else begin
              do_emit = 1'b1;
            end
          end else if (!cfg_i.ignore_carrier && !carrier_i) begin
            do_fin = 1'b1;  // carrier lost, byte dropped
          end else if (rx_byte_i == fdle_pkg::BYTE_DLE) begin
            st_o.esc_pending = 1'b1;
            st_o.esc_count   = '0;
          end else begin
            do_emit = 1'b1;
          end
        end
      end
      fdle_pkg::MODE_TICK: begin
        if (!st_i.page_done) begin
          if (st_i.esc_pending) begin
            st_o.esc_count = esc_inc[fdle_pkg::TMO_BITS-1:0];
            if (esc_inc >= {1'b0, cfg_i.esc_tmo}) begin
              do_fin   = 1'b1;
              do_clr   = 1'b1;
              fin_kind = fdle_pkg::KIND_ERROR;
            end
          end else if (!cfg_i.ignore_carrier) begin
            do_fin = !carrier_i;
          end else begin
            st_o.idle_count = idle_inc[fdle_pkg::TMO_BITS-1:0];
            if (idle_inc >= {1'b0, cfg_i.idle_tmo}) begin
              do_fin   = 1'b1;
              fin_kind = fdle_pkg::KIND_ERROR;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // byte counter saturates at all ones
    if (do_clr) begin
      cnt_next = '0;
    end else if (do_emit && (st_i.byte_count != '1)) begin
      cnt_next = st_i.byte_count + 1'b1;
    end else begin
      cnt_next = st_i.byte_count;
    end
    st_o.byte_count = cnt_next;

    if (do_fin) begin
      st_o.page_done   = 1'b1;
      st_o.esc_pending = 1'b0;
      st_o.esc_count   = '0;
      st_o.idle_count  = '0;
    end
  end

  assign cnt_wide = 32'(cnt_next);

  always_comb begin
    res_valid_o = do_fin || do_emit;
    res_o.kind  = do_fin ? fin_kind : fdle_pkg::KIND_DATA;
    res_o.out_byte = do_fin ? 8'h00 : fdle_pkg::reverse8(rx_byte_i);
    res_o.page_bytes = (cnt_wide > fdle_pkg::REPORT_MAX) ?
                       fdle_pkg::REPORT_MAX[fdle_pkg::REPORT_BITS-1:0] :
                       cnt_wide[fdle_pkg::REPORT_BITS-1:0];
    res_o.keep_page = do_fin && (cnt_wide > 32'(cfg_i.min_keep));
  end

endmodule

FILE: design/fax_dle_unstuff_bit_reverse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fax_dle_unstuff_bit_reverse_unit
// Fax page receiver: DLE unstuffing, bit reversal and page end detection.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one word per cycle when ready:
// a modem byte, a time tick or a start-of-page marker, with the carrier level.
// Output channel (out_valid_o/out_ready_i) returns at most one word per
// input: a bit-reversed data byte, or a page end (good or error) with the
// page byte count and the keep flag.
// A result is registered, in the skid entry while the result register waits.
// Throughput: one input per cycle while in_ready_o is high; the page
// state updates in a single combinational step, so words follow with no gap.
// A two-entry output buffer (result register plus skid) lets an input be
// taken while a result waits; in_ready_o drops only once both are full.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i, taken at
// once. Users write it only while the unit is idle; the unit does not check.
// Reset: the unit waits for a start marker; bytes and ticks before it are
// dropped. Registers return to ignore_carrier 0, idle timeout 15000,
// escape timeout 4000 and min keep 256; the output buffer empties.
// ----------------------------------------------------------------------------
module fax_dle_unstuff_bit_reverse_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        carrier_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [23:0] page_bytes_o,
  output logic        keep_page_o
);

  fdle_pkg::cfg_t cfg_q;
  fdle_pkg::st_t  st_q, st_d;
  fdle_pkg::res_t res;
  fdle_pkg::res_t out_q, skid_q;
  logic           res_valid;
  logic           out_valid_q, skid_valid_q;
  logic           in_acc, res_new, out_free;

  fdle_core u_core (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .carrier_i   (carrier_i),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign res_new    = in_acc && res_valid;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_carrier <= 1'b0;
      cfg_q.idle_tmo       <= 16'd15000;
      cfg_q.esc_tmo        <= 16'd4000;
      cfg_q.min_keep       <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (fdle_pkg::cfg_idx_e'(cfg_idx_i))
        fdle_pkg::CFG_IGNORE_CARRIER: cfg_q.ignore_carrier <= cfg_wdata_i[0];
        fdle_pkg::CFG_IDLE_TMO:       cfg_q.idle_tmo       <= cfg_wdata_i;
        fdle_pkg::CFG_ESC_TMO:        cfg_q.esc_tmo        <= cfg_wdata_i;
        fdle_pkg::CFG_MIN_KEEP:       cfg_q.min_keep       <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{page_done: 1'b1, esc_pending: 1'b0, idle_count: '0,
                esc_count: '0, byte_count: '0};
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_new;
      end else begin
        out_valid_q  <= res_new;
      end
    end else if (res_new) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (res_new) begin
          skid_q <= res;
        end
      end else if (res_new) begin
        out_q <= res;
      end
    end else if (res_new) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign out_byte_o   = out_q.out_byte;
  assign page_bytes_o = out_q.page_bytes;
  assign keep_page_o  = out_q.keep_page;

`ifndef SYNTH
  // skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // page end result leaves the unit waiting for a start marker
  a_fin_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new && (res.kind != fdle_pkg::KIND_DATA)) |=> st_q.page_done)
    else $error("page end did not close the page");

  // data words never carry the keep flag, page ends never carry a byte
  a_out_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == fdle_pkg::KIND_DATA) ? !keep_page_o
                                                     : (out_byte_o == 8'h00)))
    else $error("result fields inconsistent with kind");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fax DLE unstuffing / bit reversal unit.
// ----------------------------------------------------------------------------
// A short directed table covers the edge cases: bytes before a start, DLE
// escapes, page end on ETX, carrier drop, restart while escaped, and both
// timeouts. It is followed by random fax pages under nine register settings
// and three handshake stall patterns. Every result word is compared with a
// behavioral page model kept in the bench or a result from the directed table.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic             is_cfg;
    fdle_pkg::cfg_t   cfg;
    fdle_pkg::mode_e  mode;
    logic [7:0]       rx;
    logic             carrier;
    logic             known;
    logic             known_has;
    fdle_pkg::res_t   known_res;
  } row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = 2'd0;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        carrier_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [23:0] page_bytes_o;
  logic        keep_page_o;

  fax_dle_unstuff_bit_reverse_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .rx_byte_i    (rx_byte_i),
    .carrier_i    (carrier_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .page_bytes_o (page_bytes_o),
    .keep_page_o  (keep_page_o)
  );

  // page model: registers and state
  fdle_pkg::cfg_t                  model_cfg;
  logic                            model_done;
  logic                            model_esc;
  logic [fdle_pkg::TMO_BITS-1:0]   model_idle_cnt;
  logic [fdle_pkg::TMO_BITS-1:0]   model_esc_cnt;
  logic [fdle_pkg::COUNT_BITS-1:0] model_bytes;

  fdle_pkg::res_t expected_page_words[$];
  row_t directed_rows[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int words_sent = 0;
  int words_taken = 0;
  int words_checked = 0;
  int good_ends = 0;
  int error_ends = 0;
  int fail_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("%0t: timeout, %0d words still expected", $time, expected_page_words.size());
    $display("Simulation FAILED");
    $finish;
  end

  // One input word through the page model; returns the result word, if any.
  task automatic fax_page_step(input fdle_pkg::mode_e m, input logic [7:0] b,
                               input logic c, output bit has, output bit taken,
                               output fdle_pkg::res_t r);
    bit              data;
    bit              ends;
    fdle_pkg::kind_e end_kind;
    int              i;
    has = 1'b0;
    taken = 1'b1;
    data = 1'b0;
    ends = 1'b0;
    end_kind = fdle_pkg::KIND_GOOD;
    r = '0;
    if (m == fdle_pkg::MODE_START) begin
      model_esc = 1'b0;
      model_idle_cnt = '0;
      model_esc_cnt = '0;
      model_bytes = '0;
      model_done = 1'b0;
    end else if (m == fdle_pkg::MODE_NONE || model_done) begin
      taken = 1'b0;
    end else if (m == fdle_pkg::MODE_BYTE) begin
      model_idle_cnt = '0;
      if (model_esc) begin
        model_esc = 1'b0;
        model_esc_cnt = '0;
        if (b == fdle_pkg::BYTE_ETX) ends = 1'b1;
        else data = 1'b1;
      end else if (!model_cfg.ignore_carrier && !c) begin
        ends = 1'b1;  // carrier gone: byte dropped
      end else if (b == fdle_pkg::BYTE_DLE) begin
        model_esc = 1'b1;
        model_esc_cnt = '0;
      end else begin
        data = 1'b1;
      end
    end else if (model_esc) begin
      // carrier is not watched while escaped
      model_esc_cnt = model_esc_cnt + 1'b1;
      if (model_esc_cnt >= model_cfg.esc_tmo) begin
        model_bytes = '0;
        ends = 1'b1;
        end_kind = fdle_pkg::KIND_ERROR;
      end
    end else if (!model_cfg.ignore_carrier) begin
      if (!c) ends = 1'b1;
    end else begin
      model_idle_cnt = model_idle_cnt + 1'b1;
      if (model_idle_cnt >= model_cfg.idle_tmo) begin
        ends = 1'b1;
        end_kind = fdle_pkg::KIND_ERROR;
      end
    end

    if (data) begin
      if (model_bytes != '1) model_bytes = model_bytes + 1'b1;
      has = 1'b1;
      r.kind = fdle_pkg::KIND_DATA;
      for (i = 0; i < 8; i++) r.out_byte[i] = b[7-i];
      r.keep_page = 1'b0;
    end
    if (ends) begin
      has = 1'b1;
      r.kind = end_kind;
      r.out_byte = 8'd0;
      r.keep_page = (model_bytes > model_cfg.min_keep);
      model_done = 1'b1;
      model_esc = 1'b0;
      model_esc_cnt = '0;
      model_idle_cnt = '0;
    end
    if (has) begin
      r.page_bytes = (model_bytes > fdle_pkg::REPORT_MAX) ?
                     fdle_pkg::REPORT_MAX[fdle_pkg::REPORT_BITS-1:0] :
                     fdle_pkg::REPORT_BITS'(model_bytes);
    end
  endtask

  // Present one word; the expectation is queued before the word goes out.
  task automatic send_word(input fdle_pkg::mode_e m, input logic [7:0] b, input logic c,
                           input bit use_known = 1'b0, input bit known_has = 1'b0,
                           input fdle_pkg::res_t known_res = '0);
    bit             has;
    bit             taken;
    fdle_pkg::res_t r;
    fax_page_step(m, b, c, has, taken, r);
    if (use_known) begin
      has = known_has;
      r = known_res;
    end
    if (has) expected_page_words.push_back(r);
    if (taken) words_taken++;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    rx_byte_i <= b;
    carrier_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Wait until every result is in, then idle so words with no result drain too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_page_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input fdle_pkg::cfg_t s);
    int i;
    logic [15:0] v;
    for (i = 0; i < 4; i++) begin
      case (fdle_pkg::cfg_idx_e'(2'(i)))
        fdle_pkg::CFG_IGNORE_CARRIER: v = {15'd0, s.ignore_carrier};
        fdle_pkg::CFG_IDLE_TMO:       v = s.idle_tmo;
        fdle_pkg::CFG_ESC_TMO:        v = s.esc_tmo;
        default:                      v = s.min_keep;
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_wdata_i <= v;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    model_cfg = s;
  endtask

  task automatic add_word(input fdle_pkg::mode_e m, input logic [7:0] b, input logic c);
    row_t w;
    w = '0;
    w.mode = m;
    w.rx = b;
    w.carrier = c;
    directed_rows.push_back(w);
  endtask

  task automatic add_known(input fdle_pkg::mode_e m, input logic [7:0] b, input logic c,
                           input bit has, input fdle_pkg::kind_e k, input logic [7:0] ob,
                           input logic [23:0] cnt, input logic keep);
    row_t w;
    w = '0;
    w.mode = m;
    w.rx = b;
    w.carrier = c;
    w.known = 1'b1;
    w.known_has = has;
    w.known_res.kind = k;
    w.known_res.out_byte = ob;
    w.known_res.page_bytes = cnt;
    w.known_res.keep_page = keep;
    directed_rows.push_back(w);
  endtask

  task automatic add_setting(input logic ign, input logic [15:0] idle,
                             input logic [15:0] esc, input logic [15:0] keep);
    row_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.cfg.ignore_carrier = ign;
    w.cfg.idle_tmo = idle;
    w.cfg.esc_tmo = esc;
    w.cfg.min_keep = keep;
    directed_rows.push_back(w);
  endtask

  // One random page: mostly well-formed traffic, some noise and broken escapes.
  task automatic run_page();
    int n;
    int k;
    int sel;
    if ($urandom_range(0, 9) != 0) send_word(fdle_pkg::MODE_START, 8'($urandom), 1'b1);
    n = $urandom_range(1, 30);
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        send_word(fdle_pkg::MODE_BYTE, 8'($urandom), $urandom_range(0, 29) != 0);
      end else if (sel < 62) begin
        send_word(fdle_pkg::MODE_BYTE, fdle_pkg::BYTE_DLE, 1'b1);
        send_word(fdle_pkg::MODE_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
      end else if (sel < 65) begin
        send_word(fdle_pkg::MODE_BYTE, fdle_pkg::BYTE_DLE, 1'b1);
        send_word(fdle_pkg::MODE_BYTE, fdle_pkg::BYTE_ETX, 1'($urandom_range(0, 1)));
      end else if (sel < 83) begin
        repeat ($urandom_range(1, 8))
          send_word(fdle_pkg::MODE_TICK, 8'($urandom), $urandom_range(0, 29) != 0);
      end else if (sel < 88) begin
        send_word(fdle_pkg::MODE_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
      end else if (sel < 90) begin
        send_word(fdle_pkg::MODE_START, 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        // escape left hanging while time passes
        send_word(fdle_pkg::MODE_BYTE, fdle_pkg::BYTE_DLE, 1'b1);
        repeat ($urandom_range(1, 12))
          send_word(fdle_pkg::MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // sink stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    fdle_pkg::res_t got;
    fdle_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = fdle_pkg::kind_e'(kind_o);
      got.out_byte = out_byte_o;
      got.page_bytes = page_bytes_o;
      got.keep_page = keep_page_o;
      if (expected_page_words.size() == 0) begin
        $display("%0t: unexpected word: kind %0d byte %h count %0d keep %0d", $time,
                 got.kind, got.out_byte, got.page_bytes, got.keep_page);
        fail_count++;
      end else begin
        want = expected_page_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected kind %0d byte %h count %0d keep %0d",
                   $time, want.kind, want.out_byte, want.page_bytes, want.keep_page);
          $display("%0t:           actual kind %0d byte %h count %0d keep %0d",
                   $time, got.kind, got.out_byte, got.page_bytes, got.keep_page);
          fail_count++;
        end
        words_checked++;
        if (want.kind == fdle_pkg::KIND_GOOD) good_ends++;
        if (want.kind == fdle_pkg::KIND_ERROR) error_ends++;
      end
    end
  end

  initial begin
    row_t           w;
    fdle_pkg::cfg_t s;
    int             ph;
    int             mark;

    model_cfg.ignore_carrier = 1'b0;
    model_cfg.idle_tmo = 16'd15000;
    model_cfg.esc_tmo = 16'd4000;
    model_cfg.min_keep = 16'd256;
    model_done = 1'b1;
    model_esc = 1'b0;
    model_idle_cnt = '0;
    model_esc_cnt = '0;
    model_bytes = '0;

    // reset register values
    add_known(fdle_pkg::MODE_TICK, 8'h00, 1'b0, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h10, 1'b1, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_START, 8'h00, 1'b1, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_NONE, 8'hFF, 1'b0, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h01, 1'b1, 1, fdle_pkg::KIND_DATA, 8'h80, 24'd1, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'hFF, 1'b1, 1, fdle_pkg::KIND_DATA, 8'hFF, 24'd2, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h10, 1'b1, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h10, 1'b0, 1, fdle_pkg::KIND_DATA, 8'h08, 24'd3, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h10, 1'b1, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_TICK, 8'h00, 1'b0, 0, fdle_pkg::KIND_DATA, 8'h00, 24'd0, 1'b0);
    add_known(fdle_pkg::MODE_BYTE, 8'h03, 1'b1, 1, fdle_pkg::KIND_GOOD, 8'h00, 24'd3, 1'b0);
    add_word(fdle_pkg::MODE_START, 8'h00, 1'b1);
    add_known(fdle_pkg::MODE_BYTE, 8'h03, 1'b1, 1, fdle_pkg::KIND_DATA, 8'hC0, 24'd1, 1'b0);
    add_word(fdle_pkg::MODE_TICK, 8'h00, 1'b1);
    add_word(fdle_pkg::MODE_BYTE, 8'h10, 1'b1);
    add_word(fdle_pkg::MODE_START, 8'h00, 1'b1);  // restart while escaped
    add_known(fdle_pkg::MODE_BYTE, 8'h00, 1'b0, 1, fdle_pkg::KIND_GOOD, 8'h00, 24'd0, 1'b0);
    add_word(fdle_pkg::MODE_START, 8'h00, 1'b1);
    add_known(fdle_pkg::MODE_TICK, 8'h00, 1'b0, 1, fdle_pkg::KIND_GOOD, 8'h00, 24'd0, 1'b0);
    // zero escape timeout fires on the first tick
    add_setting(1'b0, 16'd15000, 16'd0, 16'd0);
    add_word(fdle_pkg::MODE_START, 8'h00, 1'b1);
    add_word(fdle_pkg::MODE_BYTE, 8'h7E, 1'b1);
    add_word(fdle_pkg::MODE_BYTE, 8'h10, 1'b1);
    add_known(fdle_pkg::MODE_TICK, 8'h00, 1'b1, 1, fdle_pkg::KIND_ERROR, 8'h00, 24'd0, 1'b0);
    // idle timeout keeps the count
    add_setting(1'b1, 16'd2, 16'hFFFF, 16'd0);
    add_word(fdle_pkg::MODE_START, 8'h00, 1'b0);
    add_word(fdle_pkg::MODE_BYTE, 8'hA5, 1'b0);
    add_word(fdle_pkg::MODE_TICK, 8'h00, 1'b0);
    add_known(fdle_pkg::MODE_TICK, 8'h00, 1'b0, 1, fdle_pkg::KIND_ERROR, 8'h00, 24'd1, 1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      w = directed_rows[i];
      if (w.is_cfg) begin
        settle();
        write_cfg(w.cfg);
      end else begin
        send_word(w.mode, w.rx, w.carrier, w.known, w.known_has, w.known_res);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      src_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 73 : 0;
      sink_idle_pct = (ph < 3) ? 73 : (ph < 6) ? 24 : 0;
      s.ignore_carrier = 1'($urandom_range(0, 1));
      s.idle_tmo = 16'($urandom_range(1, 12));
      s.esc_tmo = 16'($urandom_range(1, 12));
      s.min_keep = 16'($urandom_range(0, 30));
      case (ph)
        0: begin
          s.ignore_carrier = 1'b0;
          s.idle_tmo = 16'd1;
          s.esc_tmo = 16'd1;
          s.min_keep = 16'd0;
        end
        1: begin
          s.ignore_carrier = 1'b1;
          s.idle_tmo = 16'hFFFF;
          s.esc_tmo = 16'hFFFF;
          s.min_keep = 16'hFFFF;
        end
        3: begin
          s.ignore_carrier = 1'b0;
          s.idle_tmo = 16'hFFFF;
        end
        4: begin
          s.ignore_carrier = 1'b1;
          s.idle_tmo = 16'd0;
          s.esc_tmo = 16'd0;
        end
        7: s.ignore_carrier = 1'b1;
        default: ;
      endcase
      settle();
      write_cfg(s);
      mark = words_sent;
      while (words_sent - mark < 200) run_page();
    end

    settle();
    $display("Sent %0d words (%0d acted on) over 12 register settings;", words_sent,
             words_taken);
    $display("checked %0d results: %0d good page ends, %0d error page ends.",
             words_checked, good_ends, error_ends);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
